FILE: design/assert_macros.svh
// Assertion macros shared by the encoder's checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define QPE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define QPE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/qpe_pkg.sv
// Shared types, constants and helpers of the quoted-printable encoder.
`timescale 1ns / 1ps
`default_nettype none
package qpe_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam int         APB_ADDR_W       = 4;
    localparam logic [1:0] REG_LIMIT_ENABLE = 2'd0;
    localparam logic [1:0] REG_MAX_LINE_LEN = 2'd1;
    localparam logic [1:0] REG_START_COLUMN = 2'd2;

    // Column counter
    localparam int          COL_W     = 11;
    localparam logic [10:0] COUNT_MAX = 11'd2047;

    // Characters
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_PRINT_LO  = 8'd33;
    localparam logic [7:0] CH_PRINT_HI  = 8'd126;

    // Output sequence steps: soft break, then token
    typedef enum logic [5:0] {
        STEP_BRK_EQ = 6'b000001,
        STEP_BRK_CR = 6'b000010,
        STEP_BRK_LF = 6'b000100,
        STEP_TOK    = 6'b001000,
        STEP_HEX_HI = 6'b010000,
        STEP_HEX_LO = 6'b100000
    } step_t;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       limit_enable;
        logic [9:0] max_line_length;
        logic [9:0] start_column;
    } cfg_t;

    // One classified byte: soft break first, escaped or plain token
    typedef struct packed {
        logic       brk;
        logic       esc;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        d = {4'd0, v};
        if (v < 4'd10) begin
            hex_digit = 8'h30 + d;
        end else begin
            hex_digit = 8'h37 + d;
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/qpe_front.sv
// Front end: accepts input bytes, tracks the column and decides on soft breaks.
`timescale 1ns / 1ps
`default_nettype none
module qpe_front import qpe_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [0:0] s_tuser,   // [0] first_of_string
    input  wire logic       s_tlast,   // last_of_string
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd
);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] col_base;
    logic [COL_W-1:0] col_tok;
    logic [COL_W:0]   need;
    logic [COL_W:0]   sum;
    logic [COL_W:0]   lim;
    logic [1:0]       width;
    logic             plain;
    logic             fits;
    logic             brk;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the byte and check whether its token fits on the line
    always_comb begin
        plain    = (s_tdata >= CH_PRINT_LO) && (s_tdata <= CH_PRINT_HI)
                   && (s_tdata != CH_EQUALS);
        width    = plain ? 2'd1 : 2'd3;
        col_base = s_tuser[0] ? {1'b0, cfg.start_column} : col_reg;
        need     = {1'b0, col_base} + {{COL_W-1{1'b0}}, width};
        lim      = {2'b00, cfg.max_line_length};
        fits     = (need < lim) || (s_tlast && (need <= lim));
        brk      = cfg.limit_enable && !fits;
        col_tok  = brk ? '0 : col_base;
        sum      = {1'b0, col_tok} + {{COL_W-1{1'b0}}, width};
        col_next = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COL_W-1:0];
        q_cmd.brk  = brk;
        q_cmd.esc  = !plain;
        q_cmd.data = s_tdata;
    end

    // Advance the column on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (q_push) begin
            col_reg <= col_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/qpe_queue.sv
// Short command queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module qpe_queue import qpe_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      head
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QUEUE_DEPTH[QPTR_W:0]);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/qpe_back.sv
// Back end: expands each command into output characters, one per cycle while m_tready is high.
`timescale 1ns / 1ps
`default_nettype none
module qpe_back import qpe_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_empty,
    input  wire cmd_t       q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last_of_run
);

    logic       active_reg;
    logic       active_next;
    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    step_t      step_reg;
    step_t      step_next;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_last_reg;
    logic       out_load;
    logic       emit;
    logic       is_last;
    step_t      last_step;
    logic [7:0] ch;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

    assign out_load  = !m_valid_reg || m_tready;
    assign emit      = active_reg && out_load;
    assign last_step = cmd_reg.esc ? STEP_HEX_LO : STEP_TOK;
    assign is_last   = (step_reg == last_step);
    assign q_pop     = !q_empty && (!active_reg || (emit && is_last));

    // Pick the character for the current step
    always_comb begin
        unique case (step_reg)
            STEP_BRK_EQ: ch = CH_EQUALS;
            STEP_BRK_CR: ch = CH_CR;
            STEP_BRK_LF: ch = CH_LF;
            STEP_TOK:    ch = cmd_reg.esc ? CH_EQUALS : cmd_reg.data;
            STEP_HEX_HI: ch = hex_digit(cmd_reg.data[7:4]);
            STEP_HEX_LO: ch = hex_digit(cmd_reg.data[3:0]);
            default:     ch = CH_EQUALS;
        endcase
    end

    // Take the next command or step through the current one
    always_comb begin
        active_next = active_reg;
        cmd_next    = cmd_reg;
        step_next   = step_reg;
        if (q_pop) begin
            active_next = 1'b1;
            cmd_next    = q_head;
            step_next   = q_head.brk ? STEP_BRK_EQ : STEP_TOK;
        end else if (emit && is_last) begin
            active_next = 1'b0;
        end else if (emit) begin
            unique case (step_reg)
                STEP_BRK_EQ: step_next = STEP_BRK_CR;
                STEP_BRK_CR: step_next = STEP_BRK_LF;
                STEP_BRK_LF: step_next = STEP_TOK;
                STEP_TOK:    step_next = STEP_HEX_HI;
                STEP_HEX_HI: step_next = STEP_HEX_LO;
                default:     step_next = step_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            if (out_load) begin
                m_valid_reg <= emit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        step_reg <= step_next;
        if (emit) begin
            m_data_reg <= ch;
            m_last_reg <= is_last;
        end
    end

endmodule
`default_nettype wire

FILE: design/quoted_printable_encoder.sv
// Top level of the quoted-printable encoder with soft line breaks.
`timescale 1ns / 1ps
`default_nettype none
// Encodes one byte per input transaction into one to six output characters:
// an optional soft break "=" CR LF, then the byte itself (33..126 except '=')
// or '=' and two upper-case hex digits. The output side delivers one character
// per clock while m_tready is high, so a byte costs 1, 3, 4 or 6 output
// characters; this output sequencer sets the sustained rate. The input side takes
// a byte in any cycle in which the four-entry command queue has room, so a
// stalled output does not stop input until the queue fills. The line column
// is tracked in the front end and decided at acceptance. Registers (APB, byte
// addresses): 0x0 limit_enable, 0x4 max_line_length, 0x8 start_column; write
// them only while the encoder is idle.
module quoted_printable_encoder import qpe_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]            s_tuser,   // [0] first_of_string
    input  wire logic                  s_tlast,   // last_of_string
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic                       m_tlast    // last_of_run
);

    logic       lim_en_reg;
    logic [9:0] max_len_reg;
    logic [9:0] start_col_reg;
    logic       cfg_wr;
    cfg_t       cfg;
    logic       q_push;
    cmd_t       q_cmd;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    cmd_t       q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_en_reg    <= 1'b1;
            max_len_reg   <= 10'd76;
            start_col_reg <= 10'd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LIMIT_ENABLE: lim_en_reg    <= pwdata[0];
                REG_MAX_LINE_LEN: max_len_reg   <= pwdata[9:0];
                REG_START_COLUMN: start_col_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_LIMIT_ENABLE: prdata = {31'd0, lim_en_reg};
            REG_MAX_LINE_LEN: prdata = {22'd0, max_len_reg};
            REG_START_COLUMN: prdata = {22'd0, start_col_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.limit_enable    = lim_en_reg;
    assign cfg.max_line_length = max_len_reg;
    assign cfg.start_column    = start_col_reg;

    qpe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    qpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    qpe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: design/qpe_checker.sv
// Port-level checker for the quoted-printable encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module qpe_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // A stalled character holds
    `QPE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // Reset empties the output
    `QPE_ASSERT_ALWAYS(a_out_reset, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    // Only printable characters or line ends leave the encoder
    `QPE_ASSERT(a_out_printable, aclk, aresetn, m_tvalid |-> ((m_tdata >= 8'd33) && (m_tdata <= 8'd126)) || (m_tdata == 8'h0D) || (m_tdata == 8'h0A), "unencoded character on output")

    // A soft break's CR never ends a run and is followed by LF at once
    `QPE_ASSERT(a_cr_lf, aclk, aresetn, m_tvalid && m_tready && (m_tdata == 8'h0D) |-> !m_tlast ##1 (m_tvalid && (m_tdata == 8'h0A)), "soft break broken")

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
